FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the hash engine RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SHF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in hash engine");

`define SHF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in hash engine");

`else

`define SHF_ASSERT_SAME(lbl, ante, cons)
`define SHF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/shf_pkg.sv
// Types and constants for the streaming 32-bit hash engine.
// Depends on nothing.
package shf_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 32;

    localparam logic [COUNT_W-1:0] BCNT_NONE  = 3'd0;
    localparam logic [COUNT_W-1:0] BCNT_ONE   = 3'd1;
    localparam logic [COUNT_W-1:0] BCNT_TWO   = 3'd2;
    localparam logic [COUNT_W-1:0] BCNT_THREE = 3'd3;
    localparam logic [COUNT_W-1:0] BCNT_FULL  = 3'd4;
    localparam logic [COUNT_W-1:0] BCNT_MAX   = 3'd7;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word               chunk;
        logic [COUNT_W-1:0]  byte_count;
        logic                is_first;
        logic                is_last;
        t_word               message_length;
    } t_beat;

endpackage

FILE: rtl/core/shf_mix.sv
// Combinational chunk mix, tail mix and final avalanche of the hash engine.
// Depends on shf_pkg.
module shf_mix (
    input  shf_pkg::t_beat i_beat,
    input  shf_pkg::t_word i_hash,
    output shf_pkg::t_word o_hash
);
    import shf_pkg::*;

    function automatic t_word mix_full(input t_word h, input t_word c);
        t_word hv;
        t_word t;
        hv = h + {16'd0, c[15:0]};
        t  = {5'd0, c[31:16], 11'd0} ^ hv;
        hv = (hv << 16) ^ t;
        hv = hv + (hv >> 11);
        return hv;
    endfunction

    function automatic t_word mix_tail(input t_word h, input t_word c,
                                       input logic [COUNT_W-1:0] n);
        t_word hv;
        hv = h;
        case (n)
            BCNT_THREE: begin
                hv = hv + {16'd0, c[15:0]};
                hv = hv ^ (hv << 16);
                hv = hv ^ {6'd0, c[23:16], 18'd0};
                hv = hv + (hv >> 11);
            end
            BCNT_TWO: begin
                hv = hv + {16'd0, c[15:0]};
                hv = hv ^ (hv << 11);
                hv = hv + (hv >> 17);
            end
            BCNT_ONE: begin
                hv = hv + {24'd0, c[7:0]};
                hv = hv ^ (hv << 10);
                hv = hv + (hv >> 1);
            end
            default: begin
                hv = h;
            end
        endcase
        return hv;
    endfunction

    function automatic t_word avalanche(input t_word h);
        t_word hv;
        hv = h ^ (h << 3);
        hv = hv + (hv >> 5);
        hv = hv ^ (hv << 4);
        hv = hv + (hv >> 17);
        hv = hv ^ (hv << 25);
        hv = hv + (hv >> 6);
        return hv;
    endfunction

    t_word w_seed;
    t_word w_mixed;
    logic  w_empty;

    assign w_seed  = i_beat.is_first ? i_beat.message_length : i_hash;
    assign w_empty = i_beat.is_first && i_beat.is_last && (i_beat.byte_count == BCNT_NONE);

    always_comb begin
        case (i_beat.byte_count) inside
            [BCNT_FULL:BCNT_MAX]: w_mixed = mix_full(w_seed, i_beat.chunk);
            default:              w_mixed = mix_tail(w_seed, i_beat.chunk, i_beat.byte_count);
        endcase
    end

    always_comb begin
        if (w_empty) begin
            o_hash = '0;
        end else if (i_beat.is_last) begin
            o_hash = avalanche(w_mixed);
        end else begin
            o_hash = w_mixed;
        end
    end

endmodule

FILE: rtl/core/superfasthash_engine_unit.sv
// Result path: the tlast beat goes through the input register, then the result register.
// Throughput: one beat per cycle unless stalled; the mix and avalanche path between the
// input register and the result register sets the cycle, and the running hash feeds back.
// The input stalls only while a tlast beat waits behind a result that is not taken.
// Reset: synchronous active-low i_rst_n clears both valid flags and the running hash.
// Top level of the streaming hash engine; depends on shf_pkg, shf_mix, assert_macros.svh.
`include "assert_macros.svh"

module superfasthash_engine_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // Bits from low up: chunk[31:0], byte_count[34:32], message_length[66:35], zero.
    input  logic [shf_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // Bit 0: is_first.
    input  logic                            i_s_tuser,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // Bits from low up: hash_value[31:0].
    output logic [shf_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import shf_pkg::*;

    logic  r_in_valid;
    t_beat r_in_beat;
    t_word r_hash;
    logic  r_out_valid;
    t_word r_out_hash;

    t_beat w_beat;
    t_word w_next_hash;
    logic  w_stall;
    logic  w_fire;

    assign w_beat.chunk          = i_s_tdata[31:0];
    assign w_beat.byte_count     = i_s_tdata[34:32];
    assign w_beat.message_length = i_s_tdata[66:35];
    assign w_beat.is_first       = i_s_tuser;
    assign w_beat.is_last        = i_s_tlast;

    assign w_stall    = r_in_valid && r_in_beat.is_last && r_out_valid && !i_m_tready;
    assign w_fire     = r_in_valid && !w_stall;
    assign o_s_tready = !w_stall;

    shf_mix u_mix (
        .i_beat (r_in_beat),
        .i_hash (r_hash),
        .o_hash (w_next_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!w_stall) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall && i_s_tvalid) begin
            r_in_beat <= w_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (w_fire) begin
            r_hash <= w_next_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_beat.is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_beat.is_last) begin
            r_out_hash <= w_next_hash;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_hash;

    `SHF_ASSERT_NEXT(a_last_gives_result, w_fire && r_in_beat.is_last, r_out_valid)
    `SHF_ASSERT_NEXT(a_result_matches_hash, w_fire && r_in_beat.is_last, r_out_hash == r_hash)
    `SHF_ASSERT_NEXT(a_hash_held_when_idle, !w_fire, $stable(r_hash))
    `SHF_ASSERT_SAME(a_stall_needs_pending, w_stall, r_out_valid && r_in_valid)

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming 32-bit hash engine.
// It depends on shf_pkg and superfasthash_engine_unit. It predicts each hash from the beats
// it sends and compares every result beat with the oldest prediction.
module testbench;
    import shf_pkg::*;

    localparam int LONG_HOLD   = 400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_BEATS = 650;

    typedef struct {
        t_beat beat;
        bit    pause;
    } t_pending;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_DATA_W-1:0]  o_m_tdata;

    t_pending     pending_beats[$];
    t_word        expected_hashes[$];
    t_beat        beat_on_bus;
    t_word        hash_state = '0;
    int unsigned  snd_idle_pct = 0;
    int unsigned  rcv_idle_pct = 0;
    int unsigned  stall_reqs = 0;
    int unsigned  stall_seen = 0;
    int unsigned  hold_left = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  beats_queued = 0;
    int unsigned  errors = 0;

    superfasthash_engine_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void predict_beat(input t_beat b, output bit emits, output t_word digest);
        t_word              h;
        t_word              hi;
        logic [COUNT_W-1:0] n;
        n = (b.byte_count > BCNT_FULL) ? BCNT_FULL : b.byte_count;
        emits = b.is_last;
        digest = '0;
        if (b.is_first && b.is_last && n == BCNT_NONE) begin
            hash_state = '0;
            return;
        end
        h = b.is_first ? b.message_length : hash_state;
        hi = t_word'(b.chunk[31:16]);
        case (n)
            BCNT_FULL: begin
                h = h + t_word'(b.chunk[15:0]);
                h = (h << 16) ^ ((hi << 11) ^ h);
                h = h + (h >> 11);
            end
            BCNT_THREE: begin
                h = h + t_word'(b.chunk[15:0]);
                h = h ^ (h << 16);
                h = h ^ (t_word'(b.chunk[23:16]) << 18);
                h = h + (h >> 11);
            end
            BCNT_TWO: begin
                h = h + t_word'(b.chunk[15:0]);
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            BCNT_ONE: begin
                h = h + t_word'(b.chunk[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
            end
        endcase
        if (b.is_last) begin
            h = h ^ (h << 3);
            h = h + (h >> 5);
            h = h ^ (h << 4);
            h = h + (h >> 17);
            h = h ^ (h << 25);
            h = h + (h >> 6);
            digest = h;
        end
        hash_state = h;
    endfunction

    always @(posedge i_clk) begin
        bit       emits;
        t_word    digest;
        t_pending nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                predict_beat(beat_on_bus, emits, digest);
                if (emits) begin
                    expected_hashes.push_back(digest);
                end
            end
            if (!s_tvalid || o_s_tready) begin
                if (pending_beats.size() != 0
                        && !(pending_beats[0].pause && expected_hashes.size() != 0)
                        && $urandom_range(99) >= snd_idle_pct) begin
                    nxt = pending_beats.pop_front();
                    beat_on_bus <= nxt.beat;
                    s_tvalid <= 1'b1;
                    s_tdata <= IN_DATA_W'({nxt.beat.message_length, nxt.beat.byte_count,
                                           nxt.beat.chunk});
                    s_tuser <= nxt.beat.is_first;
                    s_tlast <= nxt.beat.is_last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_seen != stall_reqs) begin
            m_tready <= 1'b0;
            stall_seen <= stall_seen + 1;
            hold_left <= LONG_HOLD;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (expected_hashes.size() == 0) begin
                $display("%0t: unexpected hash beat, expected none, got %08h", $time, o_m_tdata);
                errors++;
            end else begin
                want = expected_hashes.pop_front();
                if (o_m_tdata !== want) begin
                    $display("%0t: hash_value mismatch, expected %08h, got %08h",
                             $time, want, o_m_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic queue_beat(input t_word chunk, input logic [COUNT_W-1:0] count,
                              input bit first, input bit last, input t_word len,
                              input bit pause);
        t_pending p;
        p.beat.chunk = chunk;
        p.beat.byte_count = count;
        p.beat.is_first = first;
        p.beat.is_last = last;
        p.beat.message_length = len;
        p.pause = pause;
        pending_beats.push_back(p);
        beats_queued++;
    endtask

    task automatic queue_message(input int unsigned nbytes, input bit truncate,
                                 input bit pause);
        int unsigned left;
        t_word       len;
        bit          at_start;
        len = ($urandom_range(9) == 0) ? t_word'($urandom) : t_word'(nbytes);
        if (nbytes == 0) begin
            queue_beat($urandom, BCNT_NONE, 1'b1, 1'b1, len, pause);
            return;
        end
        left = nbytes;
        at_start = 1'b1;
        while (left != 0) begin
            if (truncate && left <= 4) begin
                break;
            end
            queue_beat($urandom, (left >= 4) ? BCNT_FULL : COUNT_W'(left), at_start,
                       left <= 4, len, pause && at_start);
            left = (left >= 4) ? left - 4 : 0;
            at_start = 1'b0;
        end
    endtask

    task automatic queue_random(input int unsigned target);
        int unsigned start;
        int unsigned pick;
        start = beats_queued;
        while (beats_queued - start < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                queue_beat($urandom, COUNT_W'($urandom_range(7)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), $urandom, 1'b0);
            end else begin
                queue_message(($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(20),
                              pick < 13, $urandom_range(99) == 0);
            end
        end
    endtask

    task automatic wait_pending_empty();
        while (pending_beats.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        snd_idle_pct = 10;
        rcv_idle_pct = 56;
        // A chunk without a first flag continues from the reset hash.
        queue_beat(32'h1234_5678, BCNT_FULL, 1'b0, 1'b0, 32'h0, 1'b0);
        queue_beat(32'h89AB_CDEF, BCNT_TWO, 1'b0, 1'b1, 32'h0, 1'b0);
        queue_beat(32'hFFFF_FFFF, BCNT_NONE, 1'b0, 1'b1, 32'h0, 1'b0);
        queue_beat(32'hFFFF_FFFF, BCNT_NONE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_beat(32'hFFFF_FFFF, BCNT_ONE, 1'b1, 1'b1, 32'd1, 1'b0);
        queue_beat(32'hFFFF_FFFF, BCNT_TWO, 1'b1, 1'b1, 32'd2, 1'b0);
        queue_beat(32'hFFFF_FFFF, BCNT_THREE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_beat(32'hFFFF_FFFF, BCNT_FULL, 1'b1, 1'b1, 32'd4, 1'b0);
        queue_beat(32'h0000_0000, BCNT_FULL, 1'b1, 1'b1, 32'd0, 1'b0);
        queue_beat(32'hA5A5_5A5A, 3'd5, 1'b1, 1'b1, 32'd5, 1'b0);
        queue_beat(32'h5A5A_A5A5, 3'd6, 1'b1, 1'b1, 32'd6, 1'b0);
        queue_beat(32'hFFFF_FFFF, BCNT_MAX, 1'b1, 1'b1, 32'd7, 1'b0);
        queue_beat(32'hDEAD_BEEF, BCNT_THREE, 1'b1, 1'b0, 32'd4, 1'b0);
        queue_beat(32'hCAFE_F00D, BCNT_ONE, 1'b0, 1'b1, 32'd4, 1'b0);
        queue_beat(32'h0102_0304, BCNT_FULL, 1'b1, 1'b0, 32'd9, 1'b0);
        queue_beat(32'h0506_0708, BCNT_FULL, 1'b0, 1'b0, 32'd9, 1'b0);
        queue_beat(32'hFFFF_FF09, BCNT_ONE, 1'b0, 1'b1, 32'd9, 1'b0);
        queue_beat(32'h1111_2222, BCNT_FULL, 1'b1, 1'b0, 32'd8, 1'b0);
        queue_beat(32'h3333_4444, BCNT_NONE, 1'b0, 1'b0, 32'd8, 1'b0);
        queue_beat(32'h5555_6666, BCNT_FULL, 1'b0, 1'b1, 32'd8, 1'b0);
        queue_beat(32'h8000_0001, BCNT_FULL, 1'b1, 1'b1, 32'h8000_0000, 1'b0);
        queue_random(PHASE_BEATS);
        wait_pending_empty();

        snd_idle_pct = 56;
        rcv_idle_pct = 10;
        queue_message(13, 1'b0, 1'b1);
        queue_random(PHASE_BEATS);
        wait_pending_empty();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        stall_reqs = stall_reqs + 1;
        queue_random(PHASE_BEATS);
        wait_pending_empty();

        while (expected_hashes.size() != 0 || s_tvalid) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
